// ===== src/sspl_pkg.sv =====
// shared types and constants of the slab slot page locator
// no dependencies
`default_nettype none
package sspl_pkg;
    localparam int SLOT_W  = 21;
    localparam int CNT_W   = 17;
    localparam int IDX_W   = 32;
    localparam int OFF_W   = 32;
    localparam int PAGE_W  = 20;
    localparam int CFG_IW  = 2;

    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SLOT_BYTES    = 2'd0;
    localparam t_cfg_idx CFG_SLOTS         = 2'd1;
    localparam t_cfg_idx CFG_MULTI_PAGE    = 2'd2;

    localparam logic [SLOT_W-1:0] RST_SLOT_BYTES = 21'd64;
    localparam logic [CNT_W-1:0]  RST_SLOTS      = 17'd64;
    localparam logic [SLOT_W-1:0] RST_MULTI_PAGE = 21'd1024;
endpackage
`default_nettype wire

// ===== src/sspl_div.sv =====
// pipelined restoring divider, one quotient bit per stage, sideband travels along
// standalone, used by slab_slot_page_locator_unit
`default_nettype none
module sspl_div #(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [NW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem,
    output logic [SW-1:0]      o_side
);
    logic [NW-1:0] r_vld;
    logic [NW-1:0] r_num  [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic [NW-1:0] n_num  [NW];
    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] s_num  [NW+1];
    logic [DW-1:0] s_rem  [NW+1];
    logic [DW-1:0] s_den  [NW+1];
    logic [SW-1:0] s_side [NW+1];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        s_num[0]  = i_num;
        s_rem[0]  = '0;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        for (int k = 0; k < NW; k++) begin
            s_num[k+1]  = r_num[k];
            s_rem[k+1]  = r_rem[k];
            s_den[k+1]  = r_den[k];
            s_side[k+1] = r_side[k];
        end
        for (int k = 0; k < NW; k++) begin
            t  = {s_rem[k], s_num[k][NW-1]};
            ge = (t >= {1'b0, s_den[k]});
            n_rem[k] = ge ? DW'(t - {1'b0, s_den[k]}) : t[DW-1:0];
            n_num[k] = {s_num[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_num[k]  <= n_num[k];
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NW-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_quot = r_num[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_side = r_side[NW-1];
endmodule
`default_nettype wire

// ===== src/slab_slot_page_locator_unit.sv =====
// slab slot page locator: slot index to byte offset, pages and sharing flags
// depends on sspl_pkg and sspl_div
//
//  channel   direction  signals
//  -------   ---------  ------------------------------------------------
//  request   in         i_valid / o_ready, i_slot_index
//  result    out        o_valid / i_ready, o_byte_offset .. o_config_error
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// one transfer per cycle while not stalled: two 32-stage dividers (index
// modulo slots, page over slot size), multiply and check stages, one 38-stage
// page divider, then product and output stages
// page size is a power of two, so the last page of a large slot is a shift
// synchronous active-low reset empties the pipeline and loads register defaults
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
`default_nettype none
module slab_slot_page_locator_unit #(
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sspl_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire logic [sspl_pkg::SLOT_W-1:0]  i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [sspl_pkg::IDX_W-1:0]   i_slot_index,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [sspl_pkg::OFF_W-1:0]        o_byte_offset,
    output logic [sspl_pkg::PAGE_W-1:0]       o_first_page,
    output logic [sspl_pkg::PAGE_W-1:0]       o_last_page,
    output logic                              o_crosses_pages,
    output logic                              o_first_page_shared,
    output logic                              o_last_page_shared,
    output logic                              o_config_error
);
    localparam int SW = sspl_pkg::SLOT_W;
    localparam int CW = sspl_pkg::CNT_W;
    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int PB = $clog2(PAGE_BYTES);
    localparam longint unsigned LIM = 64'h1_0000_0000 / PAGE_BYTES;
    localparam int LW = $clog2(LIM + 1);
    localparam int BW = CW + SW;
    localparam int D1S = CW + SW;
    localparam int D3S = 3 + SW + sspl_pkg::PAGE_W + sspl_pkg::OFF_W;

    logic [SW-1:0] r_slot_bytes;
    logic [CW-1:0] r_slots;
    logic [SW-1:0] r_multi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes <= sspl_pkg::RST_SLOT_BYTES;
            r_slots      <= sspl_pkg::RST_SLOTS;
            r_multi      <= sspl_pkg::RST_MULTI_PAGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sspl_pkg::CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data;
                sspl_pkg::CFG_SLOTS:      r_slots      <= i_cfg_data[CW-1:0];
                sspl_pkg::CFG_MULTI_PAGE: r_multi      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_o_vld;
    assign en      = !r_o_vld || i_ready;
    assign o_ready = en;

    // index modulo slots, page size over slot size
    logic           d1_vld, d2_vld;
    logic [31:0]    d1_q, d2_q;
    logic [CW-1:0]  d1_r;
    logic [SW-1:0]  d2_r;
    logic [D1S-1:0] d1_side;
    logic [SW-1:0]  d2_side;

    sspl_div #(.NW(32), .DW(CW), .SW(D1S)) u_div_off (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_num(i_slot_index), .i_den(r_slots), .i_side({r_slots, r_multi}),
        .o_vld(d1_vld), .o_quot(d1_q), .o_rem(d1_r), .o_side(d1_side)
    );

    sspl_div #(.NW(32), .DW(SW), .SW(SW)) u_div_per (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_num(32'(PAGE_BYTES)), .i_den(r_slot_bytes), .i_side(r_slot_bytes),
        .o_vld(d2_vld), .o_quot(d2_q), .o_rem(d2_r), .o_side(d2_side)
    );

    // multiply stage
    logic           r_m_vld;
    logic [CW-1:0]  r_m_off, r_m_n, r_m_per;
    logic [SW-1:0]  r_m_s, r_m_mpm;
    logic [BW-1:0]  r_m_byte, r_m_chunk;
    logic [LW+CW-1:0] r_m_lim;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_off   <= d1_r;
            r_m_n     <= d1_side[D1S-1:SW];
            r_m_mpm   <= d1_side[SW-1:0];
            r_m_s     <= d2_side;
            r_m_per   <= d2_q[CW-1:0];
            r_m_byte  <= BW'(d1_r) * BW'(d2_side);
            r_m_chunk <= BW'(d1_side[D1S-1:SW]) * BW'(d2_side);
            r_m_lim   <= (LW+CW)'(LW'(LIM)) * (LW+CW)'(d2_q[CW-1:0]);
        end
    end

    // check stage, last page of large slots, operands for the page divider
    logic           r_e_vld, r_e_err, r_e_large;
    logic [SW-1:0]  r_e_s;
    logic [BW-1:0]  r_e_num_a;
    logic [CW-1:0]  r_e_den_a;
    logic [sspl_pkg::PAGE_W-1:0] r_e_last;
    logic           r_e_b;
    logic           m_large, m_err;
    logic [BW-1:0]  m_end;

    always_comb begin
        m_large = r_m_s >= r_m_mpm;
        m_err   = (r_m_s == '0) || (r_m_n == '0);
        m_end   = r_m_byte + BW'(r_m_s) - BW'(1);
        if (m_large) begin
            m_err = m_err || (r_m_chunk > BW'(64'h1_0000_0000));
        end else begin
            m_err = m_err || (r_m_s > SW'(PAGE_BYTES))
                  || ((LW+CW)'(r_m_n) > r_m_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_err   <= m_err;
            r_e_large <= m_large;
            r_e_s     <= r_m_s;
            r_e_num_a <= m_large ? r_m_byte : BW'(r_m_off);
            r_e_den_a <= m_large ? CW'(PAGE_BYTES) : r_m_per;
            r_e_last  <= m_end[PB +: sspl_pkg::PAGE_W];
            r_e_b     <= m_end[PB-1:0] != PB'(PAGE_BYTES - 1);
        end
    end

    logic           d3_vld;
    logic [BW-1:0]  d3_q;
    logic [CW-1:0]  d3_r;
    logic [D3S-1:0] d3_side;

    sspl_div #(.NW(BW), .DW(CW), .SW(D3S)) u_div_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_e_vld),
        .i_num(r_e_num_a), .i_den(r_e_den_a),
        .i_side({r_e_err, r_e_large, r_e_s, r_e_last, r_e_b,
                 r_e_num_a[sspl_pkg::OFF_W-1:0]}),
        .o_vld(d3_vld), .o_quot(d3_q), .o_rem(d3_r), .o_side(d3_side)
    );

    // product stage
    logic           r_p_vld, r_p_err, r_p_large;
    logic [SW-1:0]  r_p_s;
    logic [31:0]    r_p_byte_l;
    logic [sspl_pkg::PAGE_W-1:0] r_p_first, r_p_last;
    logic           r_p_a, r_p_b;
    logic [CW+PW-1:0] r_p_pp_page;
    logic [BW-1:0]  r_p_pp_slot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_err     <= d3_side[D3S-1];
            r_p_large   <= d3_side[D3S-2];
            r_p_s       <= d3_side[D3S-3 -: SW];
            r_p_byte_l  <= d3_side[31:0];
            r_p_first   <= d3_q[sspl_pkg::PAGE_W-1:0];
            r_p_last    <= d3_side[D3S-2]
                         ? d3_side[sspl_pkg::OFF_W+1 +: sspl_pkg::PAGE_W]
                         : d3_q[sspl_pkg::PAGE_W-1:0];
            r_p_a       <= d3_r != '0;
            r_p_b       <= d3_side[sspl_pkg::OFF_W];
            r_p_pp_page <= (CW+PW)'(d3_q[CW-1:0]) * (CW+PW)'(PAGE_BYTES);
            r_p_pp_slot <= BW'(d3_r) * BW'(d3_side[D3S-3 -: SW]);
        end
    end

    // output stage
    logic [31:0] p_byte;
    logic        p_sh_first, p_sh_last;

    always_comb begin
        if (r_p_large) begin
            p_byte = r_p_byte_l;
            if (r_p_s <= SW'(PAGE_BYTES)) begin
                p_sh_first = r_p_a || r_p_b;
                p_sh_last  = r_p_a || r_p_b;
            end else begin
                p_sh_first = r_p_a;
                p_sh_last  = r_p_b;
            end
        end else begin
            p_byte     = 32'(BW'(r_p_pp_page) + r_p_pp_slot);
            p_sh_first = 1'b1;
            p_sh_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_config_error      <= r_p_err;
            o_byte_offset       <= r_p_err ? '0 : p_byte;
            o_first_page        <= r_p_err ? '0 : r_p_first;
            o_last_page         <= r_p_err ? '0 : r_p_last;
            o_crosses_pages     <= !r_p_err && (r_p_first != r_p_last);
            o_first_page_shared <= !r_p_err && p_sh_first;
            o_last_page_shared  <= !r_p_err && p_sh_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= d1_vld && d2_vld;
            r_e_vld <= r_m_vld;
            r_p_vld <= d3_vld;
            r_o_vld <= r_p_vld;
        end
    end

    assign o_valid = r_o_vld;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_config_error |-> o_byte_offset == '0 && o_first_page == '0
            && o_last_page == '0 && !o_first_page_shared && !o_last_page_shared)
        else $error("config error result carries data");

    a_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_crosses_pages == (o_first_page != o_last_page))
        else $error("cross flag disagrees with pages");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d1_vld == d2_vld)
        else $error("divider lanes out of step");
endmodule
`default_nettype wire

// ===== dv/tb_slab_slot_page_locator_unit.sv =====
// testbench of the slab slot page locator: random and directed slot lookups
// checked against a behavioral predictor held in a small scoreboard class
// depends on sspl_pkg and slab_slot_page_locator_unit
`timescale 1ns / 100ps
module tb_slab_slot_page_locator_unit;

    localparam int PAGE = 4096;
    localparam int LATENCY = 74;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [sspl_pkg::OFF_W-1:0]  byte_offset;
        logic [sspl_pkg::PAGE_W-1:0] head_page;
        logic [sspl_pkg::PAGE_W-1:0] tail_page;
        logic                        crosses_pages;
        logic                        first_page_shared;
        logic                        last_page_shared;
        logic                        config_error;
    } t_location;

    class location_scoreboard;
        longint unsigned slot_bytes;
        longint unsigned slots_in_chunk;
        longint unsigned multi_page_min;
        t_location pending[$];
        int errors;

        function void reset_regs();
            slot_bytes = sspl_pkg::RST_SLOT_BYTES;
            slots_in_chunk = sspl_pkg::RST_SLOTS;
            multi_page_min = sspl_pkg::RST_MULTI_PAGE;
            errors = 0;
        endfunction

        function void write_reg(sspl_pkg::t_cfg_idx idx, logic [sspl_pkg::SLOT_W-1:0] data);
            case (idx)
                sspl_pkg::CFG_SLOT_BYTES: slot_bytes = data;
                sspl_pkg::CFG_SLOTS: slots_in_chunk = data[sspl_pkg::CNT_W-1:0];
                sspl_pkg::CFG_MULTI_PAGE: multi_page_min = data;
                default: ;
            endcase
        endfunction

        function void note_request(logic [sspl_pkg::IDX_W-1:0] slot_index);
            t_location r;
            longint unsigned s, n, off, byte_pos, first, last, per, pages;
            bit big, err, a, b;
            s = slot_bytes;
            n = slots_in_chunk;
            big = s >= multi_page_min;
            err = 0;
            r = '0;
            if (s == 0 || n == 0) err = 1;
            else if (big) begin
                if (n * s > 64'h1_0000_0000) err = 1;
            end else if (s > PAGE) err = 1;
            else begin
                per = PAGE / s;
                pages = (n + per - 1) / per;
                if (pages * PAGE > 64'h1_0000_0000) err = 1;
            end
            if (err) begin
                r.config_error = 1;
            end else begin
                off = slot_index % n;
                if (big) begin
                    byte_pos = off * s;
                    first = byte_pos / PAGE;
                    last = (byte_pos + s - 1) / PAGE;
                    a = (byte_pos % PAGE) != 0;
                    b = ((byte_pos + s) % PAGE) != 0;
                    r.first_page_shared = (s <= PAGE) ? (a | b) : a;
                    r.last_page_shared = (s <= PAGE) ? (a | b) : b;
                end else begin
                    per = PAGE / s;
                    first = off / per;
                    last = first;
                    byte_pos = first * PAGE + (off % per) * s;
                    r.first_page_shared = 1;
                    r.last_page_shared = 1;
                end
                r.byte_offset = byte_pos[31:0];
                r.head_page = first[19:0];
                r.tail_page = last[19:0];
                r.crosses_pages = first != last;
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_location got);
            t_location exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r.byte_offset !== got.byte_offset)
                $display("%0t: byte_offset exp %h got %h", $time, exp_r.byte_offset,
                         got.byte_offset);
            if (exp_r.head_page !== got.head_page)
                $display("%0t: head_page exp %h got %h", $time, exp_r.head_page,
                         got.head_page);
            if (exp_r.tail_page !== got.tail_page)
                $display("%0t: tail_page exp %h got %h", $time, exp_r.tail_page,
                         got.tail_page);
            if (exp_r.crosses_pages !== got.crosses_pages)
                $display("%0t: crosses_pages exp %b got %b", $time, exp_r.crosses_pages,
                         got.crosses_pages);
            if (exp_r.first_page_shared !== got.first_page_shared)
                $display("%0t: first_page_shared exp %b got %b", $time,
                         exp_r.first_page_shared, got.first_page_shared);
            if (exp_r.last_page_shared !== got.last_page_shared)
                $display("%0t: last_page_shared exp %b got %b", $time,
                         exp_r.last_page_shared, got.last_page_shared);
            if (exp_r.config_error !== got.config_error)
                $display("%0t: config_error exp %b got %b", $time, exp_r.config_error,
                         got.config_error);
            if (exp_r !== got) errors++;
        endfunction
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_cfg_we = 0;
    logic [sspl_pkg::CFG_IW-1:0] i_cfg_idx = '0;
    logic [sspl_pkg::SLOT_W-1:0] i_cfg_data = '0;
    logic                        i_valid = 0;
    logic                        o_ready;
    logic [sspl_pkg::IDX_W-1:0]  i_slot_index = '0;
    logic                        o_valid;
    logic                        i_ready = 0;
    logic [sspl_pkg::OFF_W-1:0]  o_byte_offset;
    logic [sspl_pkg::PAGE_W-1:0] o_first_page;
    logic [sspl_pkg::PAGE_W-1:0] o_last_page;
    logic                        o_crosses_pages;
    logic                        o_first_page_shared;
    logic                        o_last_page_shared;
    logic                        o_config_error;

    location_scoreboard sb = new();
    bit quiet_phase = 0;
    int idle_cycles = 0;

    slab_slot_page_locator_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    // result side: random stall, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_byte_offset, o_first_page, o_last_page, o_crosses_pages,
                             o_first_page_shared, o_last_page_shared, o_config_error});
        i_ready <= quiet_phase || ($urandom_range(99) >= 8);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("slab_slot_page_locator_unit regression: fail");
            $finish;
        end
    end

    task automatic send_index(logic [sspl_pkg::IDX_W-1:0] idx);
        while (!quiet_phase && $urandom_range(99) < 8) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_slot_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(idx);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(sspl_pkg::t_cfg_idx idx, logic [sspl_pkg::SLOT_W-1:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_cfg(logic [sspl_pkg::SLOT_W-1:0] s, logic [sspl_pkg::SLOT_W-1:0] n,
                           logic [sspl_pkg::SLOT_W-1:0] m);
        write_cfg(sspl_pkg::CFG_SLOT_BYTES, s);
        write_cfg(sspl_pkg::CFG_SLOTS, n);
        write_cfg(sspl_pkg::CFG_MULTI_PAGE, m);
        i_cfg_we <= 0;
    endtask

    task automatic random_cfg();
        logic [sspl_pkg::SLOT_W-1:0] s, n, m;
        case ($urandom_range(5))
            0: s = $urandom_range(1, 64);
            1: s = $urandom_range(1, PAGE);
            2: s = $urandom_range(PAGE - 8, PAGE + 8);
            3: s = $urandom_range(1, 1 << 20);
            4: s = 1 << $urandom_range(0, 20);
            default: s = $urandom_range(0, (1 << 21) - 1);
        endcase
        case ($urandom_range(3))
            0: n = $urandom_range(1, 16);
            1: n = $urandom_range(1, 4096);
            2: n = $urandom_range(1, 65536);
            default: n = $urandom_range(0, (1 << 17) - 1);
        endcase
        case ($urandom_range(3))
            0: m = $urandom_range(1, 4096);
            1: m = s;
            2: m = $urandom_range(1, (1 << 21) - 1);
            default: m = 1 << 20;
        endcase
        if ($urandom_range(19) == 0) s = 0;
        set_cfg(s, n, m);
    endtask

    task automatic random_index(int n);
        logic [sspl_pkg::IDX_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = $urandom_range(0, 2 * n + 1);
            2: v = n - 1;
            default: v = 32'hffff_ffff - $urandom_range(0, 3);
        endcase
        send_index(v);
    endtask

    initial begin
        sb.reset_regs();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // defaults, then extremes
        send_index(0);
        send_index(63);
        send_index(64);
        send_index(32'hffff_ffff);
        drain();
        set_cfg(4096, 65536, 4096);
        send_index(1);
        send_index(65535);
        drain();
        set_cfg(4097, 3, 1);
        send_index(0); send_index(1); send_index(2);
        drain();
        set_cfg(1000, 100, 500);
        send_index(1); send_index(4); send_index(99);
        drain();
        set_cfg(1000, 100, 2000);
        send_index(5); send_index(99);
        drain();
        set_cfg(4096, 10, 8192);
        send_index(3);
        drain();
        set_cfg(0, 10, 1);
        send_index(3);
        drain();
        set_cfg(64, 0, 1024);
        send_index(3);
        drain();
        set_cfg(4097, 10, 8192);
        send_index(3);
        drain();
        set_cfg(1 << 20, 4096, 1);
        send_index(1);
        drain();
        set_cfg(1 << 20, 4097, 1);
        send_index(1);
        drain();
        set_cfg(1, 65536, (1 << 21) - 1);
        send_index(32'hffff_ffff);
        drain();
        set_cfg(2049, 65536, 1 << 20);
        send_index(65535);
        drain();
        for (int ph = 0; ph < 40; ph++) begin
            random_cfg();
            quiet_phase = (ph % 10) == 5;
            for (int k = 0; k < 20; k++) random_index(sb.slots_in_chunk);
            drain();
        end
        quiet_phase = 0;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("slab_slot_page_locator_unit regression: pass");
        else
            $display("slab_slot_page_locator_unit regression: fail");
        $finish;
    end
endmodule
